FILE: rtl/sst_pkg.sv
// Shared types and constants for the small set store.
// Holds the transaction payload structs, operation and status codes and the
// sequencer state type. No dependencies.
package sst_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam logic [1:0] OP_INSERT    = 2'd0;
  localparam logic [1:0] OP_QUERY     = 2'd1;
  localparam logic [1:0] OP_DELETE    = 2'd2;
  localparam logic [1:0] OP_INTERSECT = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic               set_select;
    logic signed [31:0] value;
    logic [5:0]         index;
  } in_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] element;
    logic [6:0]         count;
    logic [1:0]         status;
    logic               last;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRD,
    S_SCMP,
    S_MATCH,
    S_ARD,
    S_AKEY,
    S_DRD,
    S_DWR,
    S_FIN
  } st_t;

endpackage

FILE: rtl/small_set_store.sv
// Small set store: two ordered sets of 32-bit values with one shared comparator.
// Insert and query walk the addressed set one entry at a time; delete moves
// the later entries down one by one; intersect searches set B for each entry
// of set A. Output stalls lengthen any of these.
// One transaction at a time; in_ready is high only between items.
// Reset (rst_n low, synchronous): counts cleared, no pending result; the entry
// memories are not cleared and need no clearing pass.
module small_set_store #(
  parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sst_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sst_pkg::out_t out_data
);
  import sst_pkg::*;

  // CW holds a count up to CAPACITY; AW addresses one entry.
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Entry memories, one write and one registered read port each.
  logic [31:0] mem_a_r [CAPACITY];
  logic [31:0] mem_b_r [CAPACITY];
  logic [31:0] rda_r, rdb_r;

  st_t                st_r, st_nxt;
  logic [1:0]         op_r, op_nxt;
  logic               sel_r, sel_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic [CW-1:0]      i_r, i_nxt;
  logic [CW-1:0]      j_r, j_nxt;
  logic               hit_r, hit_nxt;
  logic               pend_r, pend_nxt;
  logic signed [31:0] pend_elem_r, pend_elem_nxt;
  logic [1:0]         stat_r, stat_nxt;
  logic [CW-1:0]      cnt_a_r, cnt_a_nxt;
  logic [CW-1:0]      cnt_b_r, cnt_b_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0]   wr_data;
  logic          we_a, we_b;

  // Search set: B for intersect, else the addressed set.
  logic          srch_b;
  logic [CW-1:0] srch_cnt, sel_cnt, in_cnt, i_inc;
  logic [31:0]   srch_data, sel_data;
  logic          eq, slot_free, in_rng;

  assign srch_b    = (op_r == OP_INTERSECT) || sel_r;
  assign srch_cnt  = srch_b ? cnt_b_r : cnt_a_r;
  assign srch_data = srch_b ? rdb_r : rda_r;
  assign sel_cnt   = sel_r ? cnt_b_r : cnt_a_r;
  assign sel_data  = sel_r ? rdb_r : rda_r;
  assign i_inc     = i_r + CW'(1);

  // The one shared comparator: stored entry against the search key.
  assign eq = (srch_data == key_r);

  // The output register can take a new transaction this cycle.
  assign slot_free = !out_valid_r || out_ready;

  // Delete index check against the count of the addressed set.
  assign in_cnt = in_data.set_select ? cnt_b_r : cnt_a_r;
  assign in_rng = (7'(in_data.index) < 7'(in_cnt));

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next state of the sequencer.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.opcode)
            OP_INSERT: st_nxt = S_SRD;
            OP_QUERY:  st_nxt = S_SRD;
            OP_DELETE: st_nxt = in_rng ? S_DRD : S_FIN;
            default:   st_nxt = S_ARD;
          endcase
        end
      end
      S_SRD: begin
        if (j_r < srch_cnt) begin
          st_nxt = S_SCMP;
        end else begin
          st_nxt = (op_r == OP_INTERSECT) ? S_ARD : S_FIN;
        end
      end
      S_SCMP: begin
        if (eq) begin
          st_nxt = (op_r == OP_INTERSECT) ? S_MATCH : S_FIN;
        end else begin
          st_nxt = S_SRD;
        end
      end
      S_MATCH: begin
        if (!pend_r || slot_free) begin
          st_nxt = S_ARD;
        end
      end
      S_ARD:  st_nxt = (i_r < cnt_a_r) ? S_AKEY : S_FIN;
      S_AKEY: st_nxt = S_SRD;
      S_DRD:  st_nxt = (i_inc < sel_cnt) ? S_DWR : S_FIN;
      S_DWR:  st_nxt = S_DRD;
      S_FIN: begin
        if (slot_free) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory ports and result register.
  always_comb begin
    out_t res;
    res           = '0;
    op_nxt        = op_r;
    sel_nxt       = sel_r;
    key_nxt       = key_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    hit_nxt       = hit_r;
    pend_nxt      = pend_r;
    pend_elem_nxt = pend_elem_r;
    stat_nxt      = stat_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rd_addr       = '0;
    wr_addr       = '0;
    wr_data       = '0;
    we_a          = 1'b0;
    we_b          = 1'b0;

    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_data.opcode;
          sel_nxt  = in_data.set_select;
          key_nxt  = in_data.value;
          hit_nxt  = 1'b0;
          pend_nxt = 1'b0;
          j_nxt    = '0;
          i_nxt    = '0;
          stat_nxt = ST_OK;
          if (in_data.opcode == OP_DELETE) begin
            if (in_rng) begin
              i_nxt = CW'(in_data.index);
            end else begin
              stat_nxt = ST_RANGE;
            end
          end
        end
      end
      S_SRD: begin
        rd_addr = j_r[AW-1:0];
        if (!(j_r < srch_cnt) && (op_r == OP_INTERSECT)) begin
          i_nxt = i_inc;
        end
      end
      S_SCMP: begin
        if (eq) begin
          hit_nxt = 1'b1;
        end else begin
          j_nxt = j_r + CW'(1);
        end
      end
      S_MATCH: begin
        // Hold one match back so the final one can carry last.
        if (!pend_r || slot_free) begin
          if (pend_r) begin
            res.found     = 1'b1;
            res.element   = pend_elem_r;
            res.count     = 7'(sel_cnt);
            res.status    = ST_OK;
            res.last      = 1'b0;
            out_data_nxt  = res;
            out_valid_nxt = 1'b1;
          end
          pend_nxt      = 1'b1;
          pend_elem_nxt = key_r;
          i_nxt         = i_inc;
        end
      end
      S_ARD: begin
        rd_addr = i_r[AW-1:0];
        j_nxt   = '0;
      end
      S_AKEY: begin
        key_nxt = rda_r;
      end
      S_DRD: begin
        rd_addr = i_inc[AW-1:0];
        if (!(i_inc < sel_cnt)) begin
          if (sel_r) begin
            cnt_b_nxt = cnt_b_r - CW'(1);
          end else begin
            cnt_a_nxt = cnt_a_r - CW'(1);
          end
        end
      end
      S_DWR: begin
        // Close the gap: move the next entry down by one.
        wr_addr = i_r[AW-1:0];
        wr_data = sel_data;
        we_a    = !sel_r;
        we_b    = sel_r;
        i_nxt   = i_inc;
      end
      S_FIN: begin
        if (slot_free) begin
          res.count  = 7'(sel_cnt);
          res.status = ST_OK;
          res.last   = 1'b1;
          case (op_r)
            OP_INSERT: begin
              if (hit_r) begin
                res.status = ST_DUP;
              end else if (sel_cnt == CW'(CAPACITY)) begin
                res.status = ST_FULL;
              end else begin
                wr_addr   = sel_cnt[AW-1:0];
                wr_data   = key_r;
                we_a      = !sel_r;
                we_b      = sel_r;
                res.count = 7'(sel_cnt + CW'(1));
                if (sel_r) begin
                  cnt_b_nxt = cnt_b_r + CW'(1);
                end else begin
                  cnt_a_nxt = cnt_a_r + CW'(1);
                end
              end
            end
            OP_QUERY: res.found = hit_r;
            OP_DELETE: res.status = stat_r;
            default: begin
              res.found   = pend_r;
              res.element = pend_r ? pend_elem_r : '0;
            end
          endcase
          out_data_nxt  = res;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    sel_r       <= sel_nxt;
    key_r       <= key_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    hit_r       <= hit_nxt;
    pend_r      <= pend_nxt;
    pend_elem_r <= pend_elem_nxt;
    stat_r      <= stat_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a_r[wr_addr] <= wr_data;
    end
    rda_r <= mem_a_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b_r[wr_addr] <= wr_data;
    end
    rdb_r <= mem_b_r[rd_addr];
  end

  // Counts never pass the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= CW'(CAPACITY)) && (cnt_b_r <= CW'(CAPACITY)))
    else $error("set count above capacity");

  // A full report always carries the capacity as its count.
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FULL) |-> (out_data.count == 7'(CAPACITY)))
    else $error("full status with count below capacity");

  // A found result is never an error result.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> (out_data.status == ST_OK))
    else $error("found result with error status");

  // An accepted transaction keeps the block busy for the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accepting a transaction");

endmodule
